// ===== hw/rtl/source_byte_tokenizer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// source byte tokenizer assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef SOURCE_BYTE_TOKENIZER_UNIT_MACROS_SVH
`define SOURCE_BYTE_TOKENIZER_UNIT_MACROS_SVH

// invariant checked at every edge
`define SBT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// implication checked at every edge
`define SBT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/sbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_pkg
// types, token codes, keyword table and scan step functions of the tokenizer
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int OFFSET_WIDTH = 32;
  localparam int LINE_WIDTH   = 24;
  localparam int KW_DEPTH     = 9;
  localparam int KW_COUNT     = 46;
  localparam int RES_DEPTH    = 4;

  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX  = '1;
  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;

  // token kinds
  localparam logic [6:0] TK_EOF = 7'd0, TK_IDENT = 7'd1, TK_INT = 7'd2, TK_FLOAT = 7'd3;
  localparam logic [6:0] TK_STR = 7'd4, TK_CHAR = 7'd5, TK_UNKNOWN = 7'd6, TK_KW_BASE = 7'd7;
  localparam logic [6:0] TK_LPAREN = 7'd53, TK_RPAREN = 7'd54, TK_LBRACE = 7'd55;
  localparam logic [6:0] TK_RBRACE = 7'd56, TK_LBRACK = 7'd57, TK_RBRACK = 7'd58;
  localparam logic [6:0] TK_SEMI = 7'd59, TK_COMMA = 7'd60, TK_DOT = 7'd61;
  localparam logic [6:0] TK_QUEST = 7'd62, TK_AT = 7'd63, TK_TILDE = 7'd64;
  localparam logic [6:0] TK_CARET = 7'd65, TK_PERCENT = 7'd66;
  localparam logic [6:0] TK_PLUS = 7'd67, TK_PLUS_EQ = 7'd68, TK_MINUS = 7'd69;
  localparam logic [6:0] TK_MINUS_EQ = 7'd70, TK_ARROW = 7'd71, TK_STAR = 7'd72;
  localparam logic [6:0] TK_STAR_EQ = 7'd73, TK_SLASH = 7'd74, TK_SLASH_EQ = 7'd75;
  localparam logic [6:0] TK_BANG = 7'd76, TK_NE = 7'd77, TK_ASSIGN = 7'd78;
  localparam logic [6:0] TK_EQ = 7'd79, TK_FAT_ARROW = 7'd80, TK_LT = 7'd81;
  localparam logic [6:0] TK_SHL = 7'd82, TK_LE = 7'd83, TK_GT = 7'd84;
  localparam logic [6:0] TK_SHR = 7'd85, TK_GE = 7'd86, TK_AMP = 7'd87;
  localparam logic [6:0] TK_AND = 7'd88, TK_PIPE = 7'd89, TK_OR = 7'd90;
  localparam logic [6:0] TK_COLON = 7'd91, TK_SCOPE = 7'd92;

  // error codes
  localparam logic [1:0] ERR_NONE = 2'd0, ERR_STR = 2'd1, ERR_CHAR = 2'd2, ERR_UNEXP = 2'd3;

  // scan modes
  localparam logic [3:0] M_IDLE = 4'd0, M_OP = 4'd1, M_COMMENT = 4'd2, M_IDENT = 4'd3;
  localparam logic [3:0] M_INT = 4'd4, M_DOT = 4'd5, M_FRAC = 4'd6, M_EXPSIGN = 4'd7;
  localparam logic [3:0] M_EXP = 4'd8, M_STR = 4'd9, M_CHOPEN = 4'd10, M_CHESC = 4'd11;
  localparam logic [3:0] M_CHCLOSE = 4'd12;

  localparam logic [71:0] KW_TEXT [KW_COUNT] = '{
    "func", "return", "if", "else", "loopwhile", "break", "continue", "say",
    "grab", "link", "fall", "own", "trace", "let", "const", "type", "struct",
    "enum", "impl", "trait", "for", "in", "while", "match", "async", "await",
    "spawn", "true", "false", "null", "as", "is", "i8", "i16", "i32", "i64",
    "u8", "u16", "u32", "u64", "f32", "f64", "bool", "char", "str", "void"};

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd6, 4'd2, 4'd4, 4'd9, 4'd5, 4'd8, 4'd3, 4'd4, 4'd4, 4'd4, 4'd3,
    4'd5, 4'd3, 4'd5, 4'd4, 4'd6, 4'd4, 4'd4, 4'd5, 4'd3, 4'd2, 4'd5, 4'd5,
    4'd5, 4'd5, 4'd5, 4'd4, 4'd5, 4'd4, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3,
    4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4, 4'd3, 4'd4};

  typedef struct packed {
    logic [3:0]              mode;
    logic [OFFSET_WIDTH-1:0] off;
    logic [OFFSET_WIDTH-1:0] beg;
    logic [LINE_WIDTH-1:0]   ln;
    logic [LINE_WIDTH-1:0]   col;
    logic [3:0]              fill;
    logic                    flt;
    logic                    esc;
    logic [7:0]              held;
  } scan_t;

  typedef struct packed {
    logic [6:0]  kind;
    logic [31:0] start;
    logic [31:0] length;
    logic [23:0] line;
    logic [23:0] column;
    logic [1:0]  err;
    logic        last;
  } tok_t;

  typedef struct packed {
    scan_t      st;
    logic       taken;
    logic [1:0] n;
    tok_t       r0;
    tok_t       r1;
    tok_t       r2;
    logic       we;
    logic [3:0] wi;
    logic [7:0] wd;
  } step_t;

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_pairable(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "!" || c == "=" ||
           c == "<" || c == ">" || c == "&" || c == "|" || c == ":";
  endfunction

  function automatic logic [6:0] single_kind(logic [7:0] c);
    logic [6:0] k;
    case (c)
      "(": k = TK_LPAREN;   ")": k = TK_RPAREN;  "{": k = TK_LBRACE;
      "}": k = TK_RBRACE;   "[": k = TK_LBRACK;  "]": k = TK_RBRACK;
      ";": k = TK_SEMI;     ",": k = TK_COMMA;   ".": k = TK_DOT;
      "?": k = TK_QUEST;    "@": k = TK_AT;      "~": k = TK_TILDE;
      "^": k = TK_CARET;    "%": k = TK_PERCENT; "+": k = TK_PLUS;
      "-": k = TK_MINUS;    "*": k = TK_STAR;    "/": k = TK_SLASH;
      "!": k = TK_BANG;     "=": k = TK_ASSIGN;  "<": k = TK_LT;
      ">": k = TK_GT;       "&": k = TK_AMP;     "|": k = TK_PIPE;
      ":": k = TK_COLON;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [6:0] pair_kind(logic [7:0] a, logic [7:0] b);
    logic [6:0] k;
    k = TK_EOF;
    case (a)
      "+": if (b == "=") k = TK_PLUS_EQ;
      "-": if (b == "=") k = TK_MINUS_EQ; else if (b == ">") k = TK_ARROW;
      "*": if (b == "=") k = TK_STAR_EQ;
      "/": if (b == "=") k = TK_SLASH_EQ;
      "!": if (b == "=") k = TK_NE;
      "=": if (b == "=") k = TK_EQ; else if (b == ">") k = TK_FAT_ARROW;
      "<": if (b == "<") k = TK_SHL; else if (b == "=") k = TK_LE;
      ">": if (b == ">") k = TK_SHR; else if (b == "=") k = TK_GE;
      "&": if (b == "&") k = TK_AND;
      "|": if (b == "|") k = TK_OR;
      ":": if (b == ":") k = TK_SCOPE;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

  function automatic logic [6:0] kw_kind(logic [KW_DEPTH-1:0][7:0] w, logic [3:0] fill);
    logic [71:0] key;
    logic [6:0]  k;
    key = '0;
    k   = TK_IDENT;
    for (int i = 0; i < KW_DEPTH; i++) begin
      if (4'(i) < fill) key = {key[63:0], w[i]};
    end
    if (fill <= 4'(KW_DEPTH)) begin
      for (int j = 0; j < KW_COUNT; j++) begin
        if (key == KW_TEXT[j] && fill == KW_LEN[j]) k = TK_KW_BASE + 7'(j);
      end
    end
    return k;
  endfunction

  function automatic scan_t count_byte(scan_t s, logic [7:0] c);
    scan_t t;
    t = s;
    if (s.off != OFF_MAX) t.off = s.off + 1'b1;
    if (c == 8'h0A) begin
      if (s.ln != LINE_MAX) t.ln = s.ln + 1'b1;
      t.col = LINE_WIDTH'(1);
    end else if (s.col != LINE_MAX) begin
      t.col = s.col + 1'b1;
    end
    return t;
  endfunction

  function automatic tok_t make_tok(scan_t s, logic [6:0] kind, logic [1:0] err);
    tok_t r;
    logic [OFFSET_WIDTH-1:0] len;
    len      = s.off - s.beg;
    r.kind   = kind;
    r.start  = s.beg;
    r.length = len;
    r.line   = s.ln;
    r.column = s.col - len[LINE_WIDTH-1:0];
    r.err    = err;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic step_t feed(scan_t s, logic [7:0] c, logic [6:0] wk);
    step_t f;
    scan_t t;
    logic [6:0] k;
    f       = '0;
    f.st    = s;
    f.taken = 1'b1;
    k       = pair_kind(s.held, c);
    case (s.mode)
      M_IDLE: begin
        if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A) begin
          f.st = count_byte(s, c);
        end else begin
          t     = s;
          t.beg = s.off;
          t     = count_byte(t, c);
          f.st  = t;
          if (is_alpha(c) || c == "_") begin
            f.we      = 1'b1;
            f.wi      = 4'd0;
            f.wd      = c;
            f.st.fill = 4'd1;
            f.st.mode = M_IDENT;
          end else if (is_digit(c)) begin
            f.st.flt  = 1'b0;
            f.st.mode = M_INT;
          end else if (c == "\"") begin
            f.st.esc  = 1'b0;
            f.st.mode = M_STR;
          end else if (c == "'") begin
            f.st.mode = M_CHOPEN;
          end else if (is_pairable(c)) begin
            f.st.held = c;
            f.st.mode = M_OP;
          end else begin
            f.n = 2'd1;
            if (single_kind(c) != TK_EOF) f.r0 = make_tok(t, single_kind(c), ERR_NONE);
            else f.r0 = make_tok(t, TK_UNKNOWN, ERR_UNEXP);
          end
        end
      end
      M_OP: begin
        f.st.mode = M_IDLE;
        if (s.held == "/" && c == "/") begin
          f.st      = count_byte(s, c);
          f.st.mode = M_COMMENT;
        end else if (k != TK_EOF) begin
          f.st      = count_byte(s, c);
          f.st.mode = M_IDLE;
          f.n       = 2'd1;
          f.r0      = make_tok(f.st, k, ERR_NONE);
        end else begin
          f.n     = 2'd1;
          f.r0    = make_tok(s, single_kind(s.held), ERR_NONE);
          f.taken = 1'b0;
        end
      end
      M_COMMENT: begin
        if (c == 8'h0A) begin
          f.st.mode = M_IDLE;
          f.taken   = 1'b0;
        end else begin
          f.st = count_byte(s, c);
        end
      end
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == "_") begin
          f.st = count_byte(s, c);
          if (s.fill < 4'(KW_DEPTH)) begin
            f.we = 1'b1;
            f.wi = s.fill;
            f.wd = c;
          end
          if (s.fill <= 4'(KW_DEPTH)) f.st.fill = s.fill + 1'b1;
        end else begin
          f.st.mode = M_IDLE;
          f.n       = 2'd1;
          f.r0      = make_tok(s, wk, ERR_NONE);
          f.taken   = 1'b0;
        end
      end
      M_INT, M_FRAC: begin
        if (is_digit(c)) begin
          f.st = count_byte(s, c);
        end else if (s.mode == M_INT && c == ".") begin
          f.st.mode = M_DOT;
        end else if (c == "e" || c == "E") begin
          f.st      = count_byte(s, c);
          f.st.flt  = 1'b1;
          f.st.mode = M_EXPSIGN;
        end else begin
          f.st.mode = M_IDLE;
          f.n       = 2'd1;
          f.r0      = make_tok(s, s.flt ? TK_FLOAT : TK_INT, ERR_NONE);
          f.taken   = 1'b0;
        end
      end
      M_DOT: begin
        if (is_digit(c)) begin
          t         = count_byte(s, ".");
          f.st      = count_byte(t, c);
          f.st.flt  = 1'b1;
          f.st.mode = M_FRAC;
        end else begin
          f.r0    = make_tok(s, TK_INT, ERR_NONE);
          t       = s;
          t.beg   = s.off;
          t       = count_byte(t, ".");
          t.mode  = M_IDLE;
          f.r1    = make_tok(t, TK_DOT, ERR_NONE);
          f.st    = t;
          f.n     = 2'd2;
          f.taken = 1'b0;
        end
      end
      M_EXPSIGN, M_EXP: begin
        if (is_digit(c) || (s.mode == M_EXPSIGN && (c == "+" || c == "-"))) begin
          f.st      = count_byte(s, c);
          f.st.mode = M_EXP;
        end else begin
          f.st.mode = M_IDLE;
          f.n       = 2'd1;
          f.r0      = make_tok(s, s.flt ? TK_FLOAT : TK_INT, ERR_NONE);
          f.taken   = 1'b0;
        end
      end
      M_STR: begin
        f.st = count_byte(s, c);
        if (s.esc) begin
          f.st.esc = 1'b0;
        end else if (c == "\\") begin
          f.st.esc = 1'b1;
        end else if (c == "\"") begin
          f.st.mode = M_IDLE;
          f.n       = 2'd1;
          f.r0      = make_tok(f.st, TK_STR, ERR_NONE);
        end
      end
      M_CHOPEN: begin
        f.st      = count_byte(s, c);
        f.st.mode = (c == "\\") ? M_CHESC : M_CHCLOSE;
      end
      M_CHESC: begin
        f.st      = count_byte(s, c);
        f.st.mode = M_CHCLOSE;
      end
      M_CHCLOSE: begin
        f.st.mode = M_IDLE;
        f.n       = 2'd1;
        if (c == "'") begin
          f.st      = count_byte(s, c);
          f.st.mode = M_IDLE;
          f.r0      = make_tok(f.st, TK_CHAR, ERR_NONE);
        end else begin
          f.r0    = make_tok(s, TK_UNKNOWN, ERR_CHAR);
          f.taken = 1'b0;
        end
      end
      default: begin
        f.st.mode = M_IDLE;
        f.taken   = 1'b0;
      end
    endcase
    return f;
  endfunction

  function automatic step_t flush(scan_t s, logic [6:0] wk);
    step_t f;
    scan_t t;
    f       = '0;
    f.taken = 1'b1;
    t       = s;
    f.n     = 2'd1;
    case (s.mode)
      M_OP:      f.r0 = make_tok(s, single_kind(s.held), ERR_NONE);
      M_IDENT:   f.r0 = make_tok(s, wk, ERR_NONE);
      M_INT, M_FRAC, M_EXPSIGN, M_EXP:
                 f.r0 = make_tok(s, s.flt ? TK_FLOAT : TK_INT, ERR_NONE);
      M_DOT: begin
        f.r0  = make_tok(s, TK_INT, ERR_NONE);
        t.beg = s.off;
        t     = count_byte(t, ".");
        f.r1  = make_tok(t, TK_DOT, ERR_NONE);
        f.n   = 2'd2;
      end
      M_STR:     f.r0 = make_tok(s, TK_UNKNOWN, ERR_STR);
      M_CHOPEN, M_CHESC, M_CHCLOSE:
                 f.r0 = make_tok(s, TK_UNKNOWN, ERR_CHAR);
      default:   f.n = 2'd0;
    endcase
    t.mode = M_IDLE;
    t.esc  = 1'b0;
    t.beg  = t.off;
    case (f.n)
      2'd0:    f.r0 = make_tok(t, TK_EOF, ERR_NONE);
      2'd1:    f.r1 = make_tok(t, TK_EOF, ERR_NONE);
      default: f.r2 = make_tok(t, TK_EOF, ERR_NONE);
    endcase
    f.n  = f.n + 2'd1;
    f.st = t;
    return f;
  endfunction

endpackage

// ===== hw/rtl/sbt_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt stream interfaces
// valid/ready channels for source bytes in and tokens out
// ----------------------------------------------------------------------------
interface sbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_marker;

  modport source (output valid, char_byte, end_marker, input ready);
  modport sink   (input valid, char_byte, end_marker, output ready);
endinterface

interface sbt_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  token_kind;
  logic [31:0] token_start;
  logic [31:0] token_length;
  logic [23:0] line_number;
  logic [23:0] column_number;
  logic [1:0]  error_code;
  logic        last_result;

  modport source (output valid, token_kind, token_start, token_length, line_number,
                  column_number, error_code, last_result, input ready);
  modport sink   (input valid, token_kind, token_start, token_length, line_number,
                  column_number, error_code, last_result, output ready);
endinterface

// ===== hw/rtl/source_byte_tokenizer_unit.sv =====
`timescale 1ns / 1ps
`include "source_byte_tokenizer_unit_macros.svh"
// ----------------------------------------------------------------------------
// source_byte_tokenizer_unit
// streaming lexer: one source byte per beat in, tokens with position out
// ----------------------------------------------------------------------------
// Takes one source byte (or an end marker) per cycle while in_i.ready is high,
// scans it combinationally against the scan state registers and puts the up
// to three tokens it produces into a four-entry token queue that drains one
// token per cycle while out_o.ready is high. Input is accepted whenever the
// queue holds at most one token, so with a ready receiver a stream of one
// token per byte runs at one byte per cycle. The last token of each item has
// last_result set; an end marker always yields an end-of-file token.
module source_byte_tokenizer_unit (
  input  logic clk_i,
  input  logic rst_ni,
  sbt_in_if.sink    in_i,
  sbt_out_if.source out_o
);
  import sbt_pkg::*;

  localparam int PTR_W = $clog2(RES_DEPTH);

  scan_t                    st_q, st_d;
  logic [KW_DEPTH-1:0][7:0] win_q;
  tok_t                     fifo_q [RES_DEPTH];
  logic [PTR_W-1:0]         wr_q, rd_q;
  logic [PTR_W:0]           cnt_q, cnt_d;
  logic [6:0]               wk;
  step_t                    p1, p2, fl;
  tok_t                     res [3];
  logic [1:0]               n_res;
  logic                     win_we;
  logic [3:0]               win_wi;
  logic [7:0]               win_wd;
  logic                     in_acc, out_acc;

  assign in_i.ready = cnt_q <= (PTR_W+1)'(1);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;
  assign wk         = kw_kind(win_q, st_q.fill);

  always_comb begin
    p1     = feed(st_q, in_i.char_byte, wk);
    p2     = feed(p1.st, in_i.char_byte, wk);
    fl     = flush(st_q, wk);
    res[0] = p1.r0;
    res[1] = p1.r1;
    res[2] = p1.r2;
    n_res  = p1.n;
    win_we = p1.we;
    win_wi = p1.wi;
    win_wd = p1.wd;
    st_d   = p1.st;
    if (in_i.end_marker) begin
      res[0] = fl.r0;
      res[1] = fl.r1;
      res[2] = fl.r2;
      n_res  = fl.n;
      win_we = 1'b0;
      st_d   = fl.st;
    end else if (!p1.taken) begin
      st_d = p2.st;
      if (p2.we) begin
        win_we = 1'b1;
        win_wi = p2.wi;
        win_wd = p2.wd;
      end
      if (p2.n != 2'd0) begin
        case (p1.n)
          2'd0:    res[0] = p2.r0;
          2'd1:    res[1] = p2.r0;
          default: res[2] = p2.r0;
        endcase
        n_res = p1.n + 2'd1;
      end
    end
    if (n_res != 2'd0) begin
      case (n_res)
        2'd1:    res[0].last = 1'b1;
        2'd2:    res[1].last = 1'b1;
        default: res[2].last = 1'b1;
      endcase
    end
    cnt_d = cnt_q - (PTR_W+1)'(out_acc) + (in_acc ? (PTR_W+1)'(n_res) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '{mode: M_IDLE, off: '0, beg: '0, ln: LINE_WIDTH'(1), col: LINE_WIDTH'(1),
                 fill: '0, flt: 1'b0, esc: 1'b0, held: '0};
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_acc) begin
        st_q <= st_d;
        wr_q <= wr_q + PTR_W'(n_res);
      end
      if (out_acc) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // token queue and keyword window payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n_res) fifo_q[wr_q + PTR_W'(i)] <= res[i];
      end
      if (win_we) win_q[win_wi] <= win_wd;
    end
  end

  assign out_o.valid         = cnt_q != '0;
  assign out_o.token_kind    = fifo_q[rd_q].kind;
  assign out_o.token_start   = fifo_q[rd_q].start;
  assign out_o.token_length  = fifo_q[rd_q].length;
  assign out_o.line_number   = fifo_q[rd_q].line;
  assign out_o.column_number = fifo_q[rd_q].column;
  assign out_o.error_code    = fifo_q[rd_q].err;
  assign out_o.last_result   = fifo_q[rd_q].last;

  `SBT_ASSERT_ALWAYS(a_queue_bound, cnt_q <= (PTR_W+1)'(RES_DEPTH), "token queue overflow")
  `SBT_ASSERT_ALWAYS(a_line_nonzero, st_q.ln != '0, "line counter reached zero")
  `SBT_ASSERT_IMP(a_eof_last, out_o.valid && out_o.token_kind == TK_EOF, out_o.last_result, "eof beat not last")
  `SBT_ASSERT_IMP(a_err_unknown, out_o.valid && out_o.error_code != ERR_NONE, out_o.token_kind == TK_UNKNOWN, "error on known token")

endmodule

// ===== dv/token_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token checker
// watches the byte and token channels, predicts the token stream of each
// accepted beat with its own scanner and compares every token field by field
// ----------------------------------------------------------------------------
module token_checker
  import sbt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sbt_in_if    in_b,
  sbt_out_if   out_b,
  output int   errors_o,
  output int   pending_o,
  output int   tokens_o,
  output int   bytes_o
);

  // scanner state
  logic [3:0]  mode;
  logic [31:0] off;
  logic [31:0] beg;
  logic [23:0] ln;
  logic [23:0] col;
  logic [7:0]  win [KW_DEPTH];
  int          fill;
  bit          flt;
  bit          esc;
  logic [7:0]  held;

  tok_t step_toks [$];
  tok_t expected_toks [$];

  assign pending_o = expected_toks.size();

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %0t: %s got %0d want %0d", $time, what, got, want);
    errors_o++;
  endtask

  function automatic void bump(logic [7:0] c);
    if (off != '1) off++;
    if (c == 8'h0A) begin
      if (ln != '1) ln++;
      col = 24'd1;
    end else if (col != '1) begin
      col++;
    end
  endfunction

  function automatic void put(logic [6:0] kind, logic [1:0] err);
    tok_t t;
    logic [31:0] len;
    len      = off - beg;
    t.kind   = kind;
    t.start  = beg;
    t.length = len;
    t.line   = ln;
    t.column = col - len[23:0];
    t.err    = err;
    t.last   = 1'b0;
    if (step_toks.size() < 3) step_toks = {step_toks, t};
  endfunction

  function automatic logic [6:0] op_code(logic [7:0] c);
    case (c)
      "(": return TK_LPAREN;   ")": return TK_RPAREN;  "{": return TK_LBRACE;
      "}": return TK_RBRACE;   "[": return TK_LBRACK;  "]": return TK_RBRACK;
      ";": return TK_SEMI;     ",": return TK_COMMA;   ".": return TK_DOT;
      "?": return TK_QUEST;    "@": return TK_AT;      "~": return TK_TILDE;
      "^": return TK_CARET;    "%": return TK_PERCENT; "+": return TK_PLUS;
      "-": return TK_MINUS;    "*": return TK_STAR;    "/": return TK_SLASH;
      "!": return TK_BANG;     "=": return TK_ASSIGN;  "<": return TK_LT;
      ">": return TK_GT;       "&": return TK_AMP;     "|": return TK_PIPE;
      ":": return TK_COLON;
      default: return TK_EOF;
    endcase
  endfunction

  function automatic logic [6:0] op_pair_code(logic [7:0] a, logic [7:0] b);
    if (b == "=") begin
      case (a)
        "+": return TK_PLUS_EQ;  "-": return TK_MINUS_EQ; "*": return TK_STAR_EQ;
        "/": return TK_SLASH_EQ; "!": return TK_NE;       "=": return TK_EQ;
        "<": return TK_LE;       ">": return TK_GE;
        default: return TK_EOF;
      endcase
    end
    if (b == ">" && a == "-") return TK_ARROW;
    if (b == ">" && a == "=") return TK_FAT_ARROW;
    if (a == b && (a == "<" || a == ">" || a == "&" || a == "|" || a == ":")) begin
      case (a)
        "<": return TK_SHL; ">": return TK_SHR; "&": return TK_AND;
        "|": return TK_OR;  default: return TK_SCOPE;
      endcase
    end
    return TK_EOF;
  endfunction

  function automatic bit pairs(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "!" || c == "=" ||
           c == "<" || c == ">" || c == "&" || c == "|" || c == ":";
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [6:0] word_code();
    logic [71:0] key;
    key = '0;
    if (fill > KW_DEPTH) return TK_IDENT;
    for (int i = 0; i < fill; i++) key = {key[63:0], win[i]};
    for (int j = 0; j < KW_COUNT; j++)
      if (KW_LEN[j] == fill && KW_TEXT[j] == key) return TK_KW_BASE + 7'(j);
    return TK_IDENT;
  endfunction

  function automatic void number_done();
    put(flt ? TK_FLOAT : TK_INT, ERR_NONE);
  endfunction

  function automatic void int_then_dot();
    put(TK_INT, ERR_NONE);
    beg = off;
    bump(".");
    put(TK_DOT, ERR_NONE);
  endfunction

  // returns 0 when the byte has to be scanned again from idle
  function automatic bit scan(logic [7:0] c);
    logic [6:0] k;
    case (mode)
      M_IDLE: begin
        if (c == " " || c == 8'h0D || c == 8'h09 || c == 8'h0A) begin
          bump(c);
          return 1;
        end
        beg = off;
        bump(c);
        if (letter(c)) begin
          win[0] = c; fill = 1; mode = M_IDENT;
        end else if (digit(c)) begin
          flt = 0; mode = M_INT;
        end else if (c == "\"") begin
          esc = 0; mode = M_STR;
        end else if (c == "'") begin
          mode = M_CHOPEN;
        end else if (pairs(c)) begin
          held = c; mode = M_OP;
        end else if (op_code(c) != TK_EOF) begin
          put(op_code(c), ERR_NONE);
        end else begin
          put(TK_UNKNOWN, ERR_UNEXP);
        end
        return 1;
      end
      M_OP: begin
        mode = M_IDLE;
        if (held == "/" && c == "/") begin
          bump(c); mode = M_COMMENT; return 1;
        end
        k = op_pair_code(held, c);
        if (k != TK_EOF) begin
          bump(c); put(k, ERR_NONE); return 1;
        end
        put(op_code(held), ERR_NONE);
        return 0;
      end
      M_COMMENT: begin
        if (c == 8'h0A) begin
          mode = M_IDLE; return 0;
        end
        bump(c);
        return 1;
      end
      M_IDENT: begin
        if (letter(c) || digit(c)) begin
          bump(c);
          if (fill < KW_DEPTH) win[fill] = c;
          if (fill <= KW_DEPTH) fill++;
          return 1;
        end
        mode = M_IDLE;
        put(word_code(), ERR_NONE);
        return 0;
      end
      M_INT, M_FRAC: begin
        if (digit(c)) begin
          bump(c); return 1;
        end
        if (mode == M_INT && c == ".") begin
          mode = M_DOT; return 1;
        end
        if (c == "e" || c == "E") begin
          bump(c); flt = 1; mode = M_EXPSIGN; return 1;
        end
        mode = M_IDLE;
        number_done();
        return 0;
      end
      M_DOT: begin
        if (digit(c)) begin
          bump("."); bump(c); flt = 1; mode = M_FRAC; return 1;
        end
        mode = M_IDLE;
        int_then_dot();
        return 0;
      end
      M_EXPSIGN, M_EXP: begin
        if (digit(c) || (mode == M_EXPSIGN && (c == "+" || c == "-"))) begin
          bump(c); mode = M_EXP; return 1;
        end
        mode = M_IDLE;
        number_done();
        return 0;
      end
      M_STR: begin
        bump(c);
        if (esc) esc = 0;
        else if (c == "\\") esc = 1;
        else if (c == "\"") begin
          mode = M_IDLE; put(TK_STR, ERR_NONE);
        end
        return 1;
      end
      M_CHOPEN: begin
        bump(c);
        mode = (c == "\\") ? M_CHESC : M_CHCLOSE;
        return 1;
      end
      M_CHESC: begin
        bump(c); mode = M_CHCLOSE; return 1;
      end
      M_CHCLOSE: begin
        mode = M_IDLE;
        if (c == "'") begin
          bump(c); put(TK_CHAR, ERR_NONE); return 1;
        end
        put(TK_UNKNOWN, ERR_CHAR);
        return 0;
      end
      default: begin
        mode = M_IDLE; return 0;
      end
    endcase
  endfunction

  function automatic void end_of_source();
    case (mode)
      M_OP:                            put(op_code(held), ERR_NONE);
      M_IDENT:                         put(word_code(), ERR_NONE);
      M_INT, M_FRAC, M_EXPSIGN, M_EXP: number_done();
      M_DOT:                           int_then_dot();
      M_STR:                           put(TK_UNKNOWN, ERR_STR);
      M_CHOPEN, M_CHESC, M_CHCLOSE:    put(TK_UNKNOWN, ERR_CHAR);
      default: ;
    endcase
    mode = M_IDLE;
    esc  = 0;
    beg  = off;
    put(TK_EOF, ERR_NONE);
  endfunction

  function automatic void predict_beat(logic [7:0] c, logic e);
    step_toks.delete();
    if (e) end_of_source();
    else if (!scan(c)) void'(scan(c));
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) expected_toks = {expected_toks, step_toks[i]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tok_t w;
    if (!rst_ni) begin
      mode = M_IDLE; off = '0; beg = '0; ln = 24'd1; col = 24'd1;
      fill = 0; flt = 0; esc = 0; held = '0;
      expected_toks.delete();
      errors_o = 0; tokens_o = 0; bytes_o = 0;
    end else begin
      if (out_b.valid && out_b.ready) begin
        tokens_o++;
        if (expected_toks.size() == 0) begin
          $display("mismatch %0t: token kind %0d with none expected", $time,
                   out_b.token_kind);
          errors_o++;
        end else begin
          w = expected_toks.pop_front();
          if (out_b.token_kind !== w.kind)
            report("kind", 32'(out_b.token_kind), 32'(w.kind));
          if (out_b.token_start !== w.start) report("start", out_b.token_start, w.start);
          if (out_b.token_length !== w.length)
            report("length", out_b.token_length, w.length);
          if (out_b.line_number !== w.line)
            report("line", 32'(out_b.line_number), 32'(w.line));
          if (out_b.column_number !== w.column)
            report("column", 32'(out_b.column_number), 32'(w.column));
          if (out_b.error_code !== w.err)
            report("error", 32'(out_b.error_code), 32'(w.err));
          if (out_b.last_result !== w.last)
            report("last", 32'(out_b.last_result), 32'(w.last));
        end
      end
      if (in_b.valid && in_b.ready) begin
        bytes_o++;
        predict_beat(in_b.char_byte, in_b.end_marker);
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tokenizer testbench
// drives source bytes and end markers through several flow-control phases
// and lets the token checker score the token stream
// ----------------------------------------------------------------------------
module testbench;
  import sbt_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0] c;
    logic       e;
  } src_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sbt_in_if  in_b ();
  sbt_out_if out_b ();

  int errors, pending, tokens, bytes;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  int hold_cnt = 0;
  int quiet = 0;
  src_beat_t src_q [$];

  source_byte_tokenizer_unit dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_b), .out_o(out_b));

  token_checker tok_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_b(in_b), .out_b(out_b),
    .errors_o(errors), .pending_o(pending), .tokens_o(tokens), .bytes_o(bytes)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_b.ready <= 1'b0;
      hold_cnt = 0;
    end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
      hold_cnt++;
      out_b.ready <= 1'b0;
    end else begin
      out_b.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_b.valid && in_b.ready) || (out_b.valid && out_b.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no beat in %0d cycles", STALL_LIMIT);
        $display("source_byte_tokenizer_unit verification failed");
        $finish;
      end
    end
  end

  task automatic push_text(string s);
    src_beat_t b;
    foreach (s[i]) begin
      b.c = s[i];
      b.e = 1'b0;
      src_q = {src_q, b};
    end
  endtask

  task automatic push_end();
    src_beat_t b;
    b.c = 8'($urandom);
    b.e = 1'b1;
    src_q = {src_q, b};
  endtask

  task automatic push_byte(logic [7:0] c);
    src_beat_t b;
    b.c = c;
    b.e = 1'b0;
    src_q = {src_q, b};
  endtask

  task automatic push_word();
    string pool;
    int n;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    n = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6);
    push_byte(pool[$urandom_range(52)]);
    for (int i = 1; i < n; i++) push_byte(pool[$urandom_range(62)]);
  endtask

  task automatic push_keyword();
    int j;
    j = $urandom_range(KW_COUNT - 1);
    for (int i = KW_LEN[j] - 1; i >= 0; i--) push_byte(KW_TEXT[j][8*i +: 8]);
  endtask

  task automatic push_digits(int n);
    for (int i = 0; i < n; i++) push_byte(8'("0") + 8'($urandom_range(9)));
  endtask

  task automatic push_number();
    string ops;
    push_digits($urandom_range(1, 3));
    if ($urandom_range(1)) begin
      push_byte(".");
      if ($urandom_range(3) != 0) push_digits($urandom_range(1, 2));
    end
    if ($urandom_range(2) == 0) begin
      push_byte($urandom_range(1) ? "e" : "E");
      ops = "+-5";
      if ($urandom_range(1)) push_byte(ops[$urandom_range(2)]);
      if ($urandom_range(3) != 0) push_digits($urandom_range(1, 2));
    end
  endtask

  task automatic push_operator();
    string ops [40];
    ops = '{"(", ")", "{", "}", "[", "]", ";", ",", ".", "?", "@", "~", "^", "%",
            "+", "+=", "-", "-=", "->", "*", "*=", "/", "/=", "!", "!=", "=", "==",
            "=>", "<", "<<", "<=", ">", ">>", ">=", "&", "&&", "|", "||", ":", "::"};
    push_text(ops[$urandom_range(39)]);
  endtask

  task automatic push_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) push_keyword();
    else if (pick < 30) push_word();
    else if (pick < 45) push_number();
    else if (pick < 65) push_operator();
    else if (pick < 72) begin
      push_byte("\"");
      repeat ($urandom_range(3)) push_byte(($urandom_range(4) == 0) ? "\\" : 8'($urandom));
      if ($urandom_range(4) != 0) push_byte("\"");
    end else if (pick < 79) begin
      push_byte("'");
      if ($urandom_range(2) == 0) push_byte("\\");
      push_byte(8'($urandom));
      if ($urandom_range(4) != 0) push_byte("'");
    end else if (pick < 84) begin
      push_text("//");
      repeat ($urandom_range(4)) push_byte(8'($urandom));
      push_byte(8'h0A);
    end else if (pick < 96) begin
      push_byte(8'($urandom));
    end else begin
      push_end();
    end
    case ($urandom_range(3))
      0: push_byte(" ");
      1: push_byte(8'h0A);
      2: push_byte(8'h09);
      default: ;
    endcase
  endtask

  // drives the queued beats; valid drops only for sender idle cycles and once the queue is empty
  task automatic drain_source();
    src_beat_t b;
    bit ok;
    while (src_q.size() > 0) begin
      b = src_q.pop_front();
      while ($urandom_range(99) < send_idle_pct) begin
        in_b.valid <= 1'b0;
        @(posedge clk_i);
      end
      in_b.valid      <= 1'b1;
      in_b.char_byte  <= b.c;
      in_b.end_marker <= b.e;
      do begin
        @(negedge clk_i);
        ok = in_b.ready;
        @(posedge clk_i);
      end while (!ok);
    end
    in_b.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    in_b.valid      = 1'b0;
    in_b.char_byte  = '0;
    in_b.end_marker = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // keywords, window overflow, number forms, escapes, errors, high bytes
    push_text("loopwhile void abcdefghijk 7.x 3.5e-2 1E+9 \"a\\\"b\" '\\'' 'ab # ");
    push_byte(8'hFF);
    push_byte(8'h00);
    push_text("\"open");
    push_end();
    push_text("'\\");
    push_end();
    push_text("12.");
    push_end();
    push_end();
    drain_source();
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 83 : (phase == 3) ? 33 : 0;
      recv_stall_pct = (phase == 2) ? 83 : (phase == 3) ? 33 : 0;
      while (src_q.size() < 12) push_token();
      push_end();
      drain_source();
      wait_drained();
    end

    // long receiver hold-off while bytes keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b1;
    repeat (6) push_operator();
    while (src_q.size() < 16) push_token();
    push_end();
    drain_source();
    wait_drained();

    $display("run covered %0d source beats and %0d tokens over five flow-control phases",
             bytes, tokens);
    if (errors == 0) begin
      $display("source_byte_tokenizer_unit verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("source_byte_tokenizer_unit verification failed");
    end
    $finish;
  end

endmodule
